// File: rtl/core/bsws_pkg.sv
// shared constants, types and codes for the bounded stack with search
// no dependencies

package bsws_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = 6;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int LIMIT_W    = 7;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_PEEK   = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_SEARCH = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic load_match;
      logic shift_match;
   } cell_ctl_type;

endpackage

// File: rtl/core/bsws_cell.sv
// one stack cell: holds one entry and its search match bit
// depends on bsws_pkg

module bsws_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  bsws_pkg::cell_ctl_type            ctl,
   input  logic [bsws_pkg::DATA_WIDTH-1:0]   above_data,
   input  logic [bsws_pkg::DATA_WIDTH-1:0]   below_data,
   input  logic                              below_match,
   input  logic [bsws_pkg::DATA_WIDTH-1:0]   key,
   input  logic                              in_use,
   output logic [bsws_pkg::DATA_WIDTH-1:0]   entry,
   output logic                              match
);

   logic [bsws_pkg::DATA_WIDTH-1:0] entry_ff;
   logic                            match_ff;
   logic                            match_in;

   // entries shift toward the bottom on push and toward the top on pop
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         entry_ff <= above_data;
      end else if (ctl.pop) begin
         entry_ff <= below_data;
      end
   end

   always_comb begin
      match_in = match_ff;
      if (ctl.load_match) begin
         match_in = in_use && (entry_ff == key);
      end else if (ctl.shift_match) begin
         match_in = below_match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

// File: rtl/core/bounded_stack_with_search_top.sv
// top level of the bounded stack with search: control, count, limit and cell row
// depends on bsws_pkg and bsws_cell

// channel   ports                                   direction  handshake
// request   start, busy, req_kind, req_value        in         start && !busy
// response  rsp_valid, rsp_status .. rsp_is_full    out        rsp_valid, one cycle
// csr       csr_wr_en, csr_wr_data                  in         csr_wr_en
//
// push, pop, peek, clear and unknown kinds: result registered, valid in the cycle after accept,
// the next transaction may be accepted at the very next edge.
// search: the match bits shift one cell per cycle up the row.
// reset clears count and sets the limit to 64; no clearing pass over the cells.
// the receiver cannot stall; busy is high only while a search scans.

module bounded_stack_with_search_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [bsws_pkg::KIND_W-1:0]        req_kind,
   input  logic signed [bsws_pkg::DATA_WIDTH-1:0] req_value,
   output logic                               rsp_valid,
   output logic [bsws_pkg::STATUS_W-1:0]      rsp_status,
   output logic signed [bsws_pkg::DATA_WIDTH-1:0] rsp_data_out,
   output logic [bsws_pkg::IDX_W-1:0]         rsp_found_index,
   output logic [bsws_pkg::CNT_W-1:0]         rsp_count,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   input  logic                               csr_wr_en,
   input  logic [bsws_pkg::LIMIT_W-1:0]       csr_wr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   localparam int DW = bsws_pkg::DATA_WIDTH;
   localparam int CW = bsws_pkg::CNT_W;

   state_type                      state_ff;
   logic [CW-1:0]                  fill_ff;
   logic [bsws_pkg::LIMIT_W-1:0]   limit_ff;
   logic [CW-1:0]                  scan_ff;
   logic [DW-1:0]                  key_ff;

   logic                           rsp_valid_ff;
   logic [bsws_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [DW-1:0]                  rsp_data_ff;
   logic [bsws_pkg::IDX_W-1:0]     rsp_index_ff;
   logic [CW-1:0]                  rsp_count_ff;
   logic                           rsp_empty_ff;
   logic                           rsp_full_ff;

   bsws_pkg::cell_ctl_type         ctl;
   logic [DW-1:0]                  entry_w [bsws_pkg::DEPTH];
   logic                           match_w [bsws_pkg::DEPTH];
   logic [DW-1:0]                  key_w;

   logic                           accept;
   logic [CW-1:0]                  eff_limit;
   logic [CW-1:0]                  fill_in;
   logic [CW-1:0]                  found_pos;
   logic                           scan_done;
   bsws_pkg::kind_type             kind;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign kind      = bsws_pkg::kind_type'(req_kind);
   assign eff_limit = ({1'b0, limit_ff} > (bsws_pkg::LIMIT_W + 1)'(bsws_pkg::DEPTH))
                      ? CW'(bsws_pkg::DEPTH) : CW'(limit_ff);
   assign key_w     = (state_ff == ST_IDLE) ? req_value : key_ff;
   assign found_pos = fill_ff - CW'(1) - scan_ff;
   assign scan_done = (scan_ff == fill_ff) || match_w[0];

   // cell row control
   always_comb begin
      ctl = '0;
      if (accept) begin
         case (kind)
            bsws_pkg::KIND_PUSH: begin
               ctl.push = (fill_ff < eff_limit);
            end
            bsws_pkg::KIND_POP: begin
               ctl.pop = (fill_ff != '0);
            end
            bsws_pkg::KIND_SEARCH: begin
               ctl.load_match = 1'b1;
            end
            default: begin
               ctl = '0;
            end
         endcase
      end else if (state_ff == ST_SCAN) begin
         ctl.shift_match = !scan_done;
      end
   end

   genvar g;
   generate
      for (g = 0; g < bsws_pkg::DEPTH; g++) begin : g_cell
         logic [DW-1:0] above_w;
         logic [DW-1:0] below_w;
         logic          below_match_w;
         if (g == 0) begin : g_first
            assign above_w = req_value;
         end else begin : g_mid
            assign above_w = entry_w[g-1];
         end
         if (g == bsws_pkg::DEPTH - 1) begin : g_last
            assign below_w       = entry_w[g];
            assign below_match_w = 1'b0;
         end else begin : g_inner
            assign below_w       = entry_w[g+1];
            assign below_match_w = match_w[g+1];
         end
         bsws_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctl         (ctl),
            .above_data  (above_w),
            .below_data  (below_w),
            .below_match (below_match_w),
            .key         (key_w),
            .in_use      (CW'(g) < fill_ff),
            .entry       (entry_w[g]),
            .match       (match_w[g])
         );
      end
   endgenerate

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         case (kind)
            bsws_pkg::KIND_PUSH: begin
               if (fill_ff < eff_limit) begin
                  fill_in = fill_ff + CW'(1);
               end
            end
            bsws_pkg::KIND_POP: begin
               if (fill_ff != '0) begin
                  fill_in = fill_ff - CW'(1);
               end
            end
            bsws_pkg::KIND_CLEAR: begin
               fill_in = '0;
            end
            default: begin
               fill_in = fill_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         limit_ff     <= bsws_pkg::LIMIT_W'(64);
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         fill_ff      <= fill_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
            fill_ff  <= '0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  key_ff        <= req_value;
                  scan_ff       <= '0;
                  rsp_status_ff <= bsws_pkg::STATUS_OK;
                  rsp_data_ff   <= '0;
                  rsp_index_ff  <= '0;
                  rsp_count_ff  <= fill_in;
                  rsp_empty_ff  <= (fill_in == '0);
                  rsp_full_ff   <= (fill_in >= eff_limit);
                  case (kind)
                     bsws_pkg::KIND_PUSH: begin
                        rsp_valid_ff <= 1'b1;
                        if (fill_ff >= eff_limit) begin
                           rsp_status_ff <= bsws_pkg::STATUS_FULL;
                        end
                     end
                     bsws_pkg::KIND_POP, bsws_pkg::KIND_PEEK: begin
                        rsp_valid_ff <= 1'b1;
                        if (fill_ff == '0) begin
                           rsp_status_ff <= bsws_pkg::STATUS_EMPTY;
                        end else begin
                           rsp_data_ff <= entry_w[0];
                        end
                     end
                     bsws_pkg::KIND_SEARCH: begin
                        state_ff <= ST_SCAN;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (scan_done) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
                  if (match_w[0] && (scan_ff != fill_ff)) begin
                     rsp_status_ff <= bsws_pkg::STATUS_OK;
                     rsp_index_ff  <= found_pos[bsws_pkg::IDX_W-1:0];
                  end else begin
                     rsp_status_ff <= bsws_pkg::STATUS_NOT_FOUND;
                     rsp_index_ff  <= '0;
                  end
               end else begin
                  scan_ff <= scan_ff + CW'(1);
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_found_index = rsp_index_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule

// File: sim/tb_top.sv
// testbench for bounded_stack_with_search_top: push, pop, peek, clear, search and unknown-kind transactions
// checked one by one against a behavioral stack model kept alongside the block
// depends on bsws_pkg and the block's rtl

module tb_top;

   localparam int DEPTH         = bsws_pkg::DEPTH;
   localparam int DATA_WIDTH    = bsws_pkg::DATA_WIDTH;
   localparam int KIND_W        = bsws_pkg::KIND_W;
   localparam int IDX_W         = bsws_pkg::IDX_W;
   localparam int CNT_W         = bsws_pkg::CNT_W;
   localparam int STATUS_W      = bsws_pkg::STATUS_W;
   localparam int LIMIT_W       = bsws_pkg::LIMIT_W;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = DEPTH + 8;
   localparam int POOL_SIZE     = 8;

   typedef struct packed {
      logic [KIND_W-1:0]            kind;
      logic signed [DATA_WIDTH-1:0] value;
   } stack_op_type;

   typedef struct {
      bsws_pkg::status_type         status;
      logic signed [DATA_WIDTH-1:0] data_out;
      logic [IDX_W-1:0]             found_index;
      logic [CNT_W-1:0]             count;
      logic                         is_empty;
      logic                         is_full;
   } stack_result_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [KIND_W-1:0]            req_kind = bsws_pkg::KIND_PUSH;
   logic signed [DATA_WIDTH-1:0] req_value = '0;
   logic                         rsp_valid;
   logic [STATUS_W-1:0]          rsp_status;
   logic signed [DATA_WIDTH-1:0] rsp_data_out;
   logic [IDX_W-1:0]             rsp_found_index;
   logic [CNT_W-1:0]             rsp_count;
   logic                         rsp_is_empty;
   logic                         rsp_is_full;
   logic                         csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]           csr_wr_data = '0;

   stack_op_type     pending_ops[$];
   stack_result_type expected_results[$];

   logic signed [DATA_WIDTH-1:0] model_words[DEPTH];
   int                           model_fill;
   logic [LIMIT_W-1:0]           model_limit;

   logic signed [DATA_WIDTH-1:0] recent_values[POOL_SIZE];
   int           sender_idle = 0;
   int           issue_total = 0;
   int           accept_total = 0;
   int           mismatch_count = 0;
   int           result_total = 0;
   int           cycle_count = 0;
   bit           hold_for_drain = 1'b0;
   stack_op_type next_op;
   int           phase_limits[6];

   bounded_stack_with_search_top uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function automatic void predict_op(logic [KIND_W-1:0] op, logic signed [DATA_WIDTH-1:0] key);
      stack_result_type r;
      int cap;
      int i;
      cap = (model_limit > DEPTH) ? DEPTH : int'(model_limit);
      r.status = bsws_pkg::STATUS_OK;
      r.data_out = '0;
      r.found_index = '0;
      case (op)
         bsws_pkg::KIND_PUSH: begin
            if (model_fill >= cap) begin
               r.status = bsws_pkg::STATUS_FULL;
            end else begin
               model_words[model_fill] = key;
               model_fill++;
            end
         end
         bsws_pkg::KIND_POP: begin
            if (model_fill == 0) begin
               r.status = bsws_pkg::STATUS_EMPTY;
            end else begin
               model_fill--;
               r.data_out = model_words[model_fill];
            end
         end
         bsws_pkg::KIND_PEEK: begin
            if (model_fill == 0) r.status = bsws_pkg::STATUS_EMPTY;
            else r.data_out = model_words[model_fill - 1];
         end
         bsws_pkg::KIND_CLEAR: begin
            model_fill = 0;
         end
         bsws_pkg::KIND_SEARCH: begin
            r.status = bsws_pkg::STATUS_NOT_FOUND;
            for (i = model_fill - 1; i >= 0 && r.status == bsws_pkg::STATUS_NOT_FOUND;
                 i--) begin
               if (model_words[i] == key) begin
                  r.status = bsws_pkg::STATUS_OK;
                  r.found_index = IDX_W'(i);
               end
            end
         end
         default: ;
      endcase
      r.count = CNT_W'(model_fill);
      r.is_empty = (model_fill == 0);
      r.is_full = (model_fill >= cap);
      expected_results.push_back(r);
   endfunction

   function automatic void check_result();
      stack_result_type e;
      result_total++;
      if (expected_results.size() == 0) begin
         note_mismatch($sformatf("result %0d: unexpected, status %0d data %0d count %0d",
                                 result_total, rsp_status, rsp_data_out, rsp_count));
         return;
      end
      e = expected_results.pop_front();
      if (rsp_status !== e.status || rsp_data_out !== e.data_out ||
          rsp_found_index !== e.found_index || rsp_count !== e.count ||
          rsp_is_empty !== e.is_empty || rsp_is_full !== e.is_full) begin
         note_mismatch($sformatf({"result %0d: expected status %0d data %0d index %0d count %0d",
                                  " empty %b full %b, got status %0d data %0d index %0d",
                                  " count %0d empty %b full %b"},
                                 result_total, e.status, e.data_out, e.found_index, e.count,
                                 e.is_empty, e.is_full, rsp_status, rsp_data_out,
                                 rsp_found_index, rsp_count, rsp_is_empty, rsp_is_full));
      end
   endfunction

   // monitor and predictor
   always @(posedge clock) begin
      if (reset) begin
         model_fill = 0;
         model_limit = LIMIT_W'(DEPTH);
      end else begin
         if (rsp_valid) check_result();
         if (csr_wr_en) begin
            model_limit = csr_wr_data;
            model_fill = 0;
         end
         if (start && !busy) begin
            predict_op(req_kind, req_value);
            accept_total++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("bounded_stack_with_search_top: mismatch");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || accept_total == issue_total) begin
         if (hold_for_drain && expected_results.size() == 0) hold_for_drain = 1'b0;
         if (hold_for_drain || pending_ops.size() == 0 || $urandom_range(0, 99) < sender_idle) begin
            start <= 1'b0;
         end else begin
            next_op = pending_ops.pop_front();
            start <= 1'b1;
            req_kind <= next_op.kind;
            req_value <= next_op.value;
            issue_total++;
            hold_for_drain = ($urandom_range(0, 49) == 0);
         end
      end
   end

   function automatic void queue_op(logic [KIND_W-1:0] k, logic signed [DATA_WIDTH-1:0] v);
      pending_ops.push_back('{k, v});
      if (k == bsws_pkg::KIND_PUSH) recent_values[$urandom_range(0, POOL_SIZE - 1)] = v;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return recent_values[$urandom_range(0, POOL_SIZE - 1)];
         4: begin
            case ($urandom_range(0, 3))
               0: return {1'b1, {(DATA_WIDTH - 1){1'b0}}};
               1: return {1'b0, {(DATA_WIDTH - 1){1'b1}}};
               2: return '0;
               default: return '1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic void gen_random(int target);
      int made;
      int len;
      int i;
      logic [KIND_W-1:0] k;
      made = 0;
      while (made < target) begin
         len = $urandom_range(1, DEPTH + 6);
         if (len > target - made) len = target - made;
         case ($urandom_range(0, 9))
            0, 1: begin
               for (i = 0; i < len; i++) begin
                  k = ($urandom_range(0, 6) == 0) ? bsws_pkg::KIND_SEARCH : bsws_pkg::KIND_PUSH;
                  queue_op(k, pick_value());
               end
               made += len;
            end
            2, 3: begin
               for (i = 0; i < len; i++) begin
                  case ($urandom_range(0, 5))
                     0: k = bsws_pkg::KIND_PEEK;
                     1: k = bsws_pkg::KIND_SEARCH;
                     default: k = bsws_pkg::KIND_POP;
                  endcase
                  queue_op(k, pick_value());
               end
               made += len;
            end
            4: begin
               if ($urandom_range(0, 1)) begin
                  queue_op(bsws_pkg::KIND_CLEAR, $urandom);
                  made++;
               end else begin
                  queue_op(KIND_W'($urandom_range(bsws_pkg::KIND_SEARCH + 1,
                                                  (1 << KIND_W) - 1)), $urandom);
               end
            end
            default: begin
               queue_op(KIND_W'($urandom_range(bsws_pkg::KIND_PUSH, bsws_pkg::KIND_SEARCH)),
                        pick_value());
               made++;
            end
         endcase
      end
   endfunction

   task automatic wait_idle();
      while (pending_ops.size() != 0 || start || issue_total != accept_total ||
             expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] v);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int p;
      int k;
      for (p = 0; p < POOL_SIZE; p++) recent_values[p] = $urandom;

      // empty stack, extremes, duplicates, unknown kinds
      queue_op(bsws_pkg::KIND_PEEK, '0);
      queue_op(bsws_pkg::KIND_POP, '0);
      queue_op(bsws_pkg::KIND_SEARCH, '0);
      queue_op(bsws_pkg::KIND_PUSH, {1'b1, {(DATA_WIDTH - 1){1'b0}}});
      queue_op(bsws_pkg::KIND_PUSH, {1'b0, {(DATA_WIDTH - 1){1'b1}}});
      queue_op(bsws_pkg::KIND_PUSH, '0);
      queue_op(bsws_pkg::KIND_PUSH, '1);
      queue_op(bsws_pkg::KIND_PUSH, {1'b0, {(DATA_WIDTH - 1){1'b1}}});
      queue_op(bsws_pkg::KIND_SEARCH, {1'b0, {(DATA_WIDTH - 1){1'b1}}});
      queue_op(bsws_pkg::KIND_SEARCH, {1'b1, {(DATA_WIDTH - 1){1'b0}}});
      queue_op(bsws_pkg::KIND_SEARCH, '1);
      queue_op(bsws_pkg::KIND_SEARCH, 32'sh5a5a_5a5a);
      queue_op(bsws_pkg::KIND_PEEK, '0);
      queue_op(bsws_pkg::KIND_POP, '0);
      queue_op(bsws_pkg::KIND_POP, '0);
      for (k = bsws_pkg::KIND_SEARCH + 1; k < (1 << KIND_W); k++) queue_op(KIND_W'(k), '1);
      queue_op(bsws_pkg::KIND_CLEAR, '0);
      queue_op(bsws_pkg::KIND_POP, '0);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_idle();

      // zero limit: always full and empty
      write_limit('0);
      queue_op(bsws_pkg::KIND_PUSH, 32'sd1);
      queue_op(bsws_pkg::KIND_PEEK, '0);
      queue_op(bsws_pkg::KIND_SEARCH, 32'sd1);
      wait_idle();

      write_limit(LIMIT_W'(1));
      queue_op(bsws_pkg::KIND_PUSH, 32'sd7);
      queue_op(bsws_pkg::KIND_PUSH, 32'sd8);
      queue_op(bsws_pkg::KIND_PEEK, '0);
      wait_idle();

      // limit above depth, and the write empties a nonempty stack
      write_limit('1);
      queue_op(bsws_pkg::KIND_PEEK, '0);
      wait_idle();

      phase_limits = '{127, 2, 64, 0, 65, 0};
      phase_limits[5] = $urandom_range(1, DEPTH - 1);
      for (p = 0; p < 6; p++) begin
         write_limit(LIMIT_W'(phase_limits[p]));
         sender_idle = (p < 2) ? 29 : (p < 4) ? 83 : 0;
         gen_random(87);
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_results.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("bounded_stack_with_search_top: match");
      end else begin
         $display("bounded_stack_with_search_top: mismatch");
      end
      $finish;
   end

endmodule
